@@ hw/rtl/csab_pkg.sv @@
// csab_pkg: shared types, widths and codes of the cyclic suffix array builder
// no dependencies; used by csab_engine, the top level and the testbench
package csab_pkg;

  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 256;

  localparam int CHAR_W = 8;
  localparam int RANK_W = 10;
  localparam int STAT_W = 2;

  // request kinds
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_READ = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [CHAR_W-1:0] char_in;
    logic              is_last;
    logic [RANK_W-1:0] read_rank;
  } in_beat_t;

  typedef struct packed {
    logic [RANK_W-1:0] start_pos;
    logic [STAT_W-1:0] status;
  } out_beat_t;

  // host side controls into the build engine
  typedef struct packed {
    logic start;
    logic text_we;
  } eng_ctl_t;

  // engine status back to the host side
  typedef struct packed {
    logic busy;
    logic done;
  } eng_sts_t;

endpackage

@@ hw/rtl/csab_ram.sv @@
// csab_ram: generic single write port, single read port ram with registered read
// no dependencies
module csab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/csab_alu.sv @@
// csab_alu: shared add/subtract unit with modulo-n wrap for the build engine
// no dependencies
module csab_alu #(
  parameter int W = 12
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] n,
  input  logic         sub,
  output logic [W-1:0] res,
  output logic [W-1:0] wrapped
);

  assign res     = sub ? (a - b) : (a + b);
  // the sum of the operands stays below 2n, so one conditional subtract brings it back in range
  assign wrapped = (res >= n) ? (res - n) : res;

endmodule

@@ hw/rtl/csab_engine.sv @@
// csab_engine: prefix doubling sequencer with the text, order, shifted-order, class, new-class and bucket rams
// depends on csab_pkg, csab_ram, csab_alu
module csab_engine #(
  parameter int MAX_LEN  = csab_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = csab_pkg::ALPHABET_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  csab_pkg::eng_ctl_t              ctl,
  input  logic [$clog2(MAX_LEN+1)-1:0]    n_in,
  input  logic [$clog2(MAX_LEN)-1:0]      host_waddr,
  input  logic [csab_pkg::CHAR_W-1:0]     host_wdata,
  input  logic [$clog2(MAX_LEN)-1:0]      host_raddr,
  output logic [$clog2(MAX_LEN)-1:0]      ord_rdata,
  output csab_pkg::eng_sts_t              sts
);

  localparam int POS_W = $clog2(MAX_LEN);
  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int MAXC  = (MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET;
  localparam int CLS_W = $clog2(MAXC);
  localparam int CNT_W = $clog2(MAXC + 1);
  localparam int ALU_W = LEN_W + 1;
  localparam int CHW   = csab_pkg::CHAR_W;

  typedef enum logic [9:0] {
    E_IDLE   = 10'b00_0000_0001,
    E_INIT   = 10'b00_0000_0010,
    E_SETUP  = 10'b00_0000_0100,
    E_SHIFT  = 10'b00_0000_1000,
    E_CLR    = 10'b00_0001_0000,
    E_COUNT  = 10'b00_0010_0000,
    E_PREFIX = 10'b00_0100_0000,
    E_SORT   = 10'b00_1000_0000,
    E_RELAB  = 10'b01_0000_0000,
    E_COPY   = 10'b10_0000_0000
  } eng_st_t;

  eng_st_t          st_r, st_nxt;
  logic [1:0]       sub_r, sub_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [ALU_W-1:0] d_r, d_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic [LEN_W-1:0] nm1_r, nm1_nxt;
  logic [LEN_W-1:0] nd_r, nd_nxt;
  logic [CLS_W-1:0] ncm1_r, ncm1_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0] p_r, p_nxt;
  logic [POS_W-1:0] cur_r, cur_nxt;
  logic [CLS_W-1:0] c_r, c_nxt;
  logic [CLS_W-1:0] c1_r, c1_nxt;
  logic [CLS_W-1:0] pc1_r, pc1_nxt;
  logic [CLS_W-1:0] pc2_r, pc2_nxt;
  logic [CLS_W-1:0] label_r, label_nxt;

  // ram ports
  logic             txt_we, ord_we, shf_we, cls_we, ncl_we, bkt_we;
  logic [POS_W-1:0] txt_waddr, txt_raddr, ord_waddr, ord_raddr;
  logic [POS_W-1:0] shf_waddr, shf_raddr, cls_waddr, cls_raddr, ncl_waddr, ncl_raddr;
  logic [CLS_W-1:0] bkt_waddr, bkt_raddr;
  logic [CHW-1:0]   txt_wdata, txt_rdata;
  logic [POS_W-1:0] ord_wdata, shf_wdata, shf_rdata;
  logic [CLS_W-1:0] cls_wdata, cls_rdata, ncl_wdata, ncl_rdata;
  logic [LEN_W-1:0] bkt_wdata, bkt_rdata;

  // shared unit
  logic [ALU_W-1:0] alu_a, alu_b, alu_res, alu_wrap;
  logic             alu_sub;

  logic             last_el, last_cls;
  logic [ALU_W-1:0] d_dbl;
  logic [CLS_W-1:0] lab;

  csab_alu #(.W(ALU_W)) u_alu (
    .a(alu_a), .b(alu_b), .n(ALU_W'(n_r)), .sub(alu_sub), .res(alu_res), .wrapped(alu_wrap)
  );

  csab_ram #(.WIDTH(CHW), .DEPTH(MAX_LEN)) u_txt (
    .clk(clk), .we(txt_we), .waddr(txt_waddr), .wdata(txt_wdata),
    .raddr(txt_raddr), .rdata(txt_rdata)
  );
  csab_ram #(.WIDTH(POS_W), .DEPTH(MAX_LEN)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );
  csab_ram #(.WIDTH(POS_W), .DEPTH(MAX_LEN)) u_shf (
    .clk(clk), .we(shf_we), .waddr(shf_waddr), .wdata(shf_wdata),
    .raddr(shf_raddr), .rdata(shf_rdata)
  );
  csab_ram #(.WIDTH(CLS_W), .DEPTH(MAX_LEN)) u_cls (
    .clk(clk), .we(cls_we), .waddr(cls_waddr), .wdata(cls_wdata),
    .raddr(cls_raddr), .rdata(cls_rdata)
  );
  csab_ram #(.WIDTH(CLS_W), .DEPTH(MAX_LEN)) u_ncl (
    .clk(clk), .we(ncl_we), .waddr(ncl_waddr), .wdata(ncl_wdata),
    .raddr(ncl_raddr), .rdata(ncl_rdata)
  );
  csab_ram #(.WIDTH(LEN_W), .DEPTH(MAXC)) u_bkt (
    .clk(clk), .we(bkt_we), .waddr(bkt_waddr), .wdata(bkt_wdata),
    .raddr(bkt_raddr), .rdata(bkt_rdata)
  );

  assign last_el  = (i_r == CNT_W'(nm1_r));
  assign last_cls = (i_r == CNT_W'(ncm1_r));
  assign d_dbl    = (d_r == '0) ? ALU_W'(1) : {d_r[ALU_W-2:0], 1'b0};
  assign sts.busy = (st_r != E_IDLE);
  assign sts.done = done_r;

  always_comb begin
    st_nxt    = st_r;
    sub_nxt   = sub_r;
    done_nxt  = 1'b0;
    i_nxt     = i_r;
    d_nxt     = d_r;
    n_nxt     = n_r;
    nm1_nxt   = nm1_r;
    nd_nxt    = nd_r;
    ncm1_nxt  = ncm1_r;
    acc_nxt   = acc_r;
    p_nxt     = p_r;
    cur_nxt   = cur_r;
    c_nxt     = c_r;
    c1_nxt    = c1_r;
    pc1_nxt   = pc1_r;
    pc2_nxt   = pc2_r;
    label_nxt = label_r;
    lab       = label_r;

    txt_we = 1'b0; txt_waddr = '0; txt_wdata = '0; txt_raddr = '0;
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
    shf_we = 1'b0; shf_waddr = '0; shf_wdata = '0; shf_raddr = '0;
    cls_we = 1'b0; cls_waddr = '0; cls_wdata = '0; cls_raddr = '0;
    ncl_we = 1'b0; ncl_waddr = '0; ncl_wdata = '0; ncl_raddr = '0;
    bkt_we = 1'b0; bkt_waddr = '0; bkt_wdata = '0; bkt_raddr = '0;

    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;

    unique case (st_r)
      E_IDLE: begin
        txt_we    = ctl.text_we;
        txt_waddr = host_waddr;
        txt_wdata = host_wdata;
        ord_raddr = host_raddr;
        if (ctl.start) begin
          n_nxt   = n_in;
          nm1_nxt = LEN_W'(n_in - 1'b1);
          i_nxt   = '0;
          sub_nxt = 2'd0;
          st_nxt  = E_INIT;
        end
      end
      E_INIT: begin
        txt_raddr = POS_W'(i_r);
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          cls_we    = 1'b1;
          cls_waddr = POS_W'(i_r);
          cls_wdata = CLS_W'(txt_rdata);
          ord_we    = 1'b1;
          ord_waddr = POS_W'(i_r);
          ord_wdata = POS_W'(i_r);
          sub_nxt   = 2'd0;
          if (last_el) begin
            d_nxt    = '0;
            ncm1_nxt = CLS_W'(ALPHABET - 1);
            st_nxt   = E_SETUP;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      E_SETUP: begin
        // offset that moves a start back by d, taken modulo n
        alu_a   = ALU_W'(n_r);
        alu_b   = d_r;
        alu_sub = 1'b1;
        nd_nxt  = LEN_W'(alu_res);
        i_nxt   = '0;
        sub_nxt = 2'd0;
        st_nxt  = E_SHIFT;
      end
      E_SHIFT: begin
        ord_raddr = POS_W'(i_r);
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          alu_a     = ALU_W'(ord_rdata);
          alu_b     = ALU_W'(nd_r);
          shf_we    = 1'b1;
          shf_waddr = POS_W'(i_r);
          shf_wdata = POS_W'(alu_wrap);
          sub_nxt   = 2'd0;
          if (last_el) begin
            i_nxt  = '0;
            st_nxt = E_CLR;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      E_CLR: begin
        bkt_we    = 1'b1;
        bkt_waddr = CLS_W'(i_r);
        bkt_wdata = '0;
        if (last_cls) begin
          i_nxt   = '0;
          sub_nxt = 2'd0;
          st_nxt  = E_COUNT;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      E_COUNT: begin
        cls_raddr = POS_W'(i_r);
        bkt_raddr = cls_rdata;
        unique case (sub_r)
          2'd0: sub_nxt = 2'd1;
          2'd1: begin
            c_nxt   = cls_rdata;
            sub_nxt = 2'd2;
          end
          default: begin
            alu_a     = ALU_W'(bkt_rdata);
            alu_b     = ALU_W'(1);
            bkt_we    = 1'b1;
            bkt_waddr = c_r;
            bkt_wdata = LEN_W'(alu_res);
            sub_nxt   = 2'd0;
            if (last_el) begin
              i_nxt   = '0;
              acc_nxt = '0;
              st_nxt  = E_PREFIX;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end
        endcase
      end
      E_PREFIX: begin
        bkt_raddr = CLS_W'(i_r);
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          alu_a     = ALU_W'(bkt_rdata);
          alu_b     = ALU_W'(acc_r);
          bkt_we    = 1'b1;
          bkt_waddr = CLS_W'(i_r);
          bkt_wdata = LEN_W'(alu_res);
          acc_nxt   = LEN_W'(alu_res);
          sub_nxt   = 2'd0;
          if (last_cls) begin
            i_nxt  = CNT_W'(nm1_r);
            st_nxt = E_SORT;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      E_SORT: begin
        // walk the shifted order from the top down so that equal classes keep their order
        shf_raddr = POS_W'(i_r);
        cls_raddr = shf_rdata;
        bkt_raddr = cls_rdata;
        unique case (sub_r)
          2'd0: sub_nxt = 2'd1;
          2'd1: begin
            p_nxt   = shf_rdata;
            sub_nxt = 2'd2;
          end
          2'd2: begin
            c_nxt   = cls_rdata;
            sub_nxt = 2'd3;
          end
          default: begin
            alu_a     = ALU_W'(bkt_rdata);
            alu_b     = ALU_W'(1);
            alu_sub   = 1'b1;
            bkt_we    = 1'b1;
            bkt_waddr = c_r;
            bkt_wdata = LEN_W'(alu_res);
            ord_we    = 1'b1;
            ord_waddr = POS_W'(alu_res);
            ord_wdata = p_r;
            sub_nxt   = 2'd0;
            if (i_r == '0) begin
              label_nxt = '0;
              st_nxt    = E_RELAB;
            end else begin
              i_nxt = i_r - 1'b1;
            end
          end
        endcase
      end
      E_RELAB: begin
        ord_raddr = POS_W'(i_r);
        unique case (sub_r)
          2'd0: sub_nxt = 2'd1;
          2'd1: begin
            cur_nxt   = ord_rdata;
            cls_raddr = ord_rdata;
            sub_nxt   = 2'd2;
          end
          2'd2: begin
            c1_nxt    = cls_rdata;
            alu_a     = ALU_W'(cur_r);
            alu_b     = d_r;
            cls_raddr = POS_W'(alu_wrap);
            sub_nxt   = 2'd3;
          end
          default: begin
            // new label whenever the class pair differs from the previous rank
            alu_a = ALU_W'(label_r);
            alu_b = ALU_W'(1);
            if (i_r != '0 && (c1_r != pc1_r || cls_rdata != pc2_r)) begin
              lab = CLS_W'(alu_res);
            end
            ncl_we    = 1'b1;
            ncl_waddr = cur_r;
            ncl_wdata = lab;
            label_nxt = lab;
            pc1_nxt   = c1_r;
            pc2_nxt   = cls_rdata;
            sub_nxt   = 2'd0;
            if (last_el) begin
              i_nxt  = '0;
              st_nxt = E_COPY;
            end else begin
              i_nxt = i_r + 1'b1;
            end
          end
        endcase
      end
      E_COPY: begin
        ncl_raddr = POS_W'(i_r);
        if (sub_r == 2'd0) begin
          sub_nxt = 2'd1;
        end else begin
          cls_we    = 1'b1;
          cls_waddr = POS_W'(i_r);
          cls_wdata = ncl_rdata;
          sub_nxt   = 2'd0;
          if (last_el) begin
            ncm1_nxt = label_r;
            d_nxt    = d_dbl;
            if (d_dbl < ALU_W'(n_r)) begin
              st_nxt = E_SETUP;
            end else begin
              done_nxt = 1'b1;
              st_nxt   = E_IDLE;
            end
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      sub_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      sub_r  <= sub_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    d_r     <= d_nxt;
    n_r     <= n_nxt;
    nm1_r   <= nm1_nxt;
    nd_r    <= nd_nxt;
    ncm1_r  <= ncm1_nxt;
    acc_r   <= acc_nxt;
    p_r     <= p_nxt;
    cur_r   <= cur_nxt;
    c_r     <= c_nxt;
    c1_r    <= c1_nxt;
    pc1_r   <= pc1_nxt;
    pc2_r   <= pc2_nxt;
    label_r <= label_nxt;
  end

endmodule

@@ hw/rtl/cyclic_suffix_array_builder.sv @@
// cyclic_suffix_array_builder: top level, request handshake, result register and text length
// depends on csab_pkg and csab_engine (with csab_ram and csab_alu below it)
//
// usage
// - in channel (in_valid, in_stall, in_data) carries appends and reads, one beat per item;
//   an append stores one byte at the end of the text, a read asks for the rotation start
//   at a given rank; every beat yields exactly one out beat (start_pos, status)
// - an append while a finished table is held discards it and starts a new text;
//   an append on a full text is dropped with overflow status
// - the append marked last runs the build: prefix doubling over cyclic rotations with a
//   stable counting sort, every pass a sequencer stepping one shared add/wrap unit over
//   rams with one write and one registered read port, each pass walking its elements with
//   chained registered reads
// - a plain append gives its result in the cycle after acceptance; a read passes the read
//   state and then the result register; the last append gives its result when the build is
//   done, after R = 1 + ceil(log2 n) rounds, n the text length
// - in_stall is high while a read or a build is in flight, and while a result sits unread
//   under out_stall; one item is in the block at a time
// - the result register holds its beat steady while out_stall is high
// - reset clears the text length, the built flag and all handshake state; the rams need
//   no clearing since nothing reads an entry before it is written
module cyclic_suffix_array_builder #(
  parameter int MAX_LEN  = csab_pkg::MAX_LEN_DEF,
  parameter int ALPHABET = csab_pkg::ALPHABET_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  csab_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output csab_pkg::out_beat_t  out_data
);

  localparam int POS_W  = $clog2(MAX_LEN);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int RANK_W = csab_pkg::RANK_W;
  localparam int CHW    = csab_pkg::CHAR_W;
  localparam int CMP_W  = (LEN_W > RANK_W) ? LEN_W : RANK_W;

  typedef enum logic [2:0] {
    T_IDLE  = 3'b001,
    T_READ  = 3'b010,
    T_BUILD = 3'b100
  } top_st_t;

  top_st_t             st_r, st_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic                built_r, built_nxt;
  logic                out_valid_r, out_valid_nxt;
  csab_pkg::out_beat_t out_data_r, out_data_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic [csab_pkg::STAT_W-1:0] bstat_r, bstat_nxt;

  csab_pkg::eng_ctl_t  ctl;
  csab_pkg::eng_sts_t  sts;
  logic [POS_W-1:0]    ord_rdata;

  logic                in_acc;
  logic                is_append;
  logic [LEN_W-1:0]    eff_len;
  logic                has_room;
  logic [LEN_W-1:0]    n_new;
  logic [CHW-1:0]      ch_clip;
  logic                rank_ok;
  logic [csab_pkg::STAT_W-1:0] app_stat;

  assign in_stall  = (st_r != T_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign is_append = (in_data.req_type == csab_pkg::REQ_APPEND);

  // a held table is thrown away by the next append
  assign eff_len  = built_r ? '0 : len_r;
  assign has_room = (eff_len < LEN_W'(MAX_LEN));
  assign n_new    = has_room ? LEN_W'(eff_len + 1'b1) : eff_len;
  assign app_stat = has_room ? csab_pkg::ST_OK : csab_pkg::ST_OVERFLOW;

  // bytes outside the alphabet fold onto its top symbol
  assign ch_clip = ({1'b0, in_data.char_in} >= (CHW + 1)'(ALPHABET))
                 ? CHW'(ALPHABET - 1) : in_data.char_in;

  assign rank_ok = built_r && (CMP_W'(in_data.read_rank) < CMP_W'(len_r));

  assign ctl.text_we = in_acc && is_append && has_room;
  assign ctl.start   = in_acc && is_append && in_data.is_last;

  csab_engine #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_engine (
    .clk(clk),
    .rst_n(rst_n),
    .ctl(ctl),
    .n_in(n_new),
    .host_waddr(POS_W'(eff_len)),
    .host_wdata(ch_clip),
    .host_raddr(POS_W'(in_data.read_rank)),
    .ord_rdata(ord_rdata),
    .sts(sts)
  );

  always_comb begin
    st_nxt        = st_r;
    len_nxt       = len_r;
    built_nxt     = built_r;
    rd_ok_nxt     = rd_ok_r;
    bstat_nxt     = bstat_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    // beat taken by the receiver
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (st_r)
      T_IDLE: begin
        if (in_acc) begin
          if (is_append) begin
            built_nxt = 1'b0;
            len_nxt   = n_new;
            if (in_data.is_last) begin
              bstat_nxt = app_stat;
              st_nxt    = T_BUILD;
            end else begin
              out_valid_nxt          = 1'b1;
              out_data_nxt.start_pos = '0;
              out_data_nxt.status    = app_stat;
            end
          end else begin
            rd_ok_nxt = rank_ok;
            st_nxt    = T_READ;
          end
        end
      end
      T_READ: begin
        // order ram data for the rank arrives in the cycle after the request
        out_valid_nxt = 1'b1;
        if (rd_ok_r) begin
          out_data_nxt.start_pos = RANK_W'(ord_rdata);
          out_data_nxt.status    = csab_pkg::ST_OK;
        end else begin
          out_data_nxt.start_pos = '0;
          out_data_nxt.status    = csab_pkg::ST_BAD_READ;
        end
        st_nxt = T_IDLE;
      end
      T_BUILD: begin
        if (sts.done) begin
          built_nxt              = 1'b1;
          out_valid_nxt          = 1'b1;
          out_data_nxt.start_pos = '0;
          out_data_nxt.status    = bstat_r;
          st_nxt                 = T_IDLE;
        end
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      len_r       <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      len_r       <= len_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    rd_ok_r    <= rd_ok_nxt;
    bstat_r    <= bstat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks

  // the engine only finishes a build that the host side is waiting on
  a_done_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (st_r == T_BUILD))
    else $error("build finished outside a build");

  // while waiting on a build the engine is either working or reporting completion
  a_build_live: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == T_BUILD) |-> (sts.busy || sts.done))
    else $error("build wait with idle engine");

  // stored length never exceeds capacity
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_LEN))
    else $error("text length beyond capacity");

  // a finished table always covers a non-empty text
  a_built_len: assert property (@(posedge clk) disable iff (!rst_n)
    built_r |-> (len_r != '0))
    else $error("table built over empty text");

  // a plain append gives its result beat on the next cycle
  a_append_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_append && !in_data.is_last) |=> out_valid_r)
    else $error("append result missing");

endmodule

@@ sim/cyclic_suffix_array_builder_tb.sv @@
// cyclic_suffix_array_builder_tb: self-checking testbench for the cyclic suffix array builder
// depends on csab_pkg and the cyclic_suffix_array_builder rtl; holds its own rotation-order
// predictor in a small scoreboard class and drives the block with plain tasks
module cyclic_suffix_array_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csab_pkg::*;

  localparam int TEXT_CAP    = MAX_LEN_DEF;
  localparam int SYMBOLS     = ALPHABET_DEF;
  localparam int CYCLE_LIMIT = 3000000;

  // predictor of the rotation order plus the queue of results still owed by the block
  class rotation_order_board;
    int unsigned text_bytes[TEXT_CAP];
    int unsigned rank_to_pos[TEXT_CAP];
    int unsigned moved_order[TEXT_CAP];
    int unsigned class_of[TEXT_CAP];
    int unsigned next_class[TEXT_CAP];
    int unsigned tally[TEXT_CAP + SYMBOLS];
    int unsigned text_len;
    bit          table_ready;
    bit          failed;
    out_beat_t   pending_results[$];

    function void sort_rotations();
      int unsigned n, n_cls, d, i, p, c, slot, cur, prv, label;
      n = text_len;
      n_cls = SYMBOLS;
      if (n == 0) return;
      for (i = 0; i < n; i++) begin
        class_of[i] = text_bytes[i];
        rank_to_pos[i] = i;
      end
      d = 0;
      while (d < n) begin
        label = 0;
        // shift back by d, wrapping around the text
        for (i = 0; i < n; i++) begin
          p = rank_to_pos[i] + n - d;
          moved_order[i] = (p >= n) ? p - n : p;
        end
        // stable counting sort on the class of the rotation start
        for (i = 0; i < n_cls; i++) tally[i] = 0;
        for (i = 0; i < n; i++) if (class_of[i] < n_cls) tally[class_of[i]]++;
        for (i = 1; i < n_cls; i++) tally[i] += tally[i-1];
        for (i = n; i > 0; i--) begin
          p = moved_order[i-1];
          c = (p < n) ? class_of[p] : 0;
          if (c < n_cls && tally[c] > 0) begin
            tally[c]--;
            slot = tally[c];
            if (slot < n) rank_to_pos[slot] = p;
          end
        end
        // relabel from the pair (class at p, class at p + d)
        for (i = 0; i < n; i++) begin
          cur = rank_to_pos[i] % n;
          if (i != 0) begin
            prv = rank_to_pos[i-1] % n;
            if (class_of[cur] != class_of[prv] ||
                class_of[(cur + d) % n] != class_of[(prv + d) % n])
              label++;
          end
          next_class[cur] = label;
        end
        n_cls = label + 1;
        for (i = 0; i < n; i++) class_of[i] = next_class[i];
        d = (d == 0) ? 1 : d * 2;
      end
      table_ready = 1;
    endfunction

    function void note_request(in_beat_t b);
      out_beat_t r;
      r.start_pos = '0;
      r.status = ST_OK;
      if (b.req_type == REQ_APPEND) begin
        if (table_ready) begin
          table_ready = 0;
          text_len = 0;
        end
        if (text_len < TEXT_CAP) begin
          text_bytes[text_len] = 32'(b.char_in);
          text_len++;
        end else begin
          r.status = ST_OVERFLOW;
        end
        if (b.is_last) sort_rotations();
      end else if (table_ready && b.read_rank < text_len) begin
        r.start_pos = RANK_W'(rank_to_pos[b.read_rank]);
      end else begin
        r.status = ST_BAD_READ;
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: start_pos %0d status %0d",
                 $realtime, got.start_pos, got.status);
        failed = 1;
        return;
      end
      want = pending_results.pop_front();
      if (got.start_pos !== want.start_pos) begin
        $display("%0t: start_pos expected %0d actual %0d",
                 $realtime, want.start_pos, got.start_pos);
        failed = 1;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
        failed = 1;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_beat_t out_data;

  rotation_order_board board = new();
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  cyclic_suffix_array_builder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: checks each accepted beat, stalls in modes of random length
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // one beat on the in channel; valid stays high across a burst, gaps fall between bursts
  task automatic send_beat(in_beat_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    board.note_request(b);
    items_sent++;
  endtask

  // unused fields carry random values so every bit toggles
  task automatic append_byte(logic [CHAR_W-1:0] ch, logic last);
    in_beat_t b;
    b.req_type = REQ_APPEND;
    b.char_in = ch;
    b.is_last = last;
    b.read_rank = RANK_W'($urandom_range(0, 1023));
    send_beat(b);
  endtask

  task automatic read_rank(logic [RANK_W-1:0] rank);
    in_beat_t b;
    b.req_type = REQ_READ;
    b.char_in = CHAR_W'($urandom_range(0, 255));
    b.is_last = 1'($urandom_range(0, 1));
    b.read_rank = rank;
    send_beat(b);
  endtask

  // one well-formed text: random content from a narrow or full alphabet, mixed with bytes of a repeated pattern
  task automatic load_and_query(int unsigned len, int unsigned reads);
    int unsigned base, span, period, i;
    logic [CHAR_W-1:0] pat[8];
    case ($urandom_range(0, 3))
      0: span = 2;
      1: span = 3;
      2: span = 26;
      default: span = 256;
    endcase
    base = $urandom_range(0, 256 - span);
    period = $urandom_range(1, 8);
    for (i = 0; i < 8; i++) pat[i] = CHAR_W'(base + $urandom_range(0, span - 1));
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) append_byte(pat[i % period], i == len - 1);
      else append_byte(CHAR_W'(base + $urandom_range(0, span - 1)), i == len - 1);
      // noise: a read while the text is still open
      if (i != len - 1 && $urandom_range(0, 15) == 0)
        read_rank(RANK_W'($urandom_range(0, 1023)));
    end
    for (i = 0; i < reads; i++) begin
      if ($urandom_range(0, 7) == 0) read_rank(RANK_W'($urandom_range(len, 1023)));
      else read_rank(RANK_W'($urandom_range(0, len - 1)));
    end
  endtask

  initial begin
    int unsigned i, len;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reads before any build, byte extremes, rank extremes, tiny texts
    read_rank(0);
    read_rank(10'h3FF);
    append_byte(8'h00, 1'b0);
    append_byte(8'hFF, 1'b0);
    append_byte(8'hAA, 1'b0);
    append_byte(8'h55, 1'b1);
    for (i = 0; i < 5; i++) read_rank(RANK_W'(i));
    read_rank(10'h3FF);
    read_rank(10'h155);
    read_rank(10'h2AA);
    // fully periodic text, ties between equal rotations
    append_byte(8'h61, 1'b0);
    append_byte(8'h61, 1'b1);
    read_rank(0);
    read_rank(1);
    // single byte text
    append_byte(8'h7E, 1'b1);
    read_rank(0);
    read_rank(1);

    // random part: mostly short texts, now and then a longer one; the full text below
    // brings the total close to the intended item count
    while (items_sent < 100) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      load_and_query(len, $urandom_range(1, 20));
    end

    // full text, overflowing appends, then a build over all of it
    for (i = 0; i < TEXT_CAP; i++) append_byte(CHAR_W'($urandom_range(0, 3)), 1'b0);
    append_byte(CHAR_W'($urandom_range(0, 255)), 1'b0);
    append_byte(CHAR_W'($urandom_range(0, 255)), 1'b1);
    read_rank(0);
    read_rank(10'h3FF);
    for (i = 0; i < 15; i++) read_rank(RANK_W'($urandom_range(0, 1023)));
    in_valid <= 1'b0;

    // drain, then a short tail to catch stray results
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (!board.failed && board.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/csab_pkg.sv
hw/rtl/csab_ram.sv
hw/rtl/csab_alu.sv
hw/rtl/csab_engine.sv
hw/rtl/cyclic_suffix_array_builder.sv
sim/cyclic_suffix_array_builder_tb.sv
